// ===== sv/sem_pkg.sv =====
// shared types and constants for the sobel edge magnitude block
// used by sem_ctrl, sem_datapath and sobel_edge_magnitude; no dependencies
package sem_pkg;

	localparam int unsigned WCFG_W = 12;     // image_width register
	localparam int unsigned HCFG_W = 13;     // image_height register
	localparam int unsigned CFG_W = 13;      // write data width
	localparam int unsigned MAX_HEIGHT = 4096;
	localparam int unsigned ROW_W = 14;      // input row counter, runs past the frame
	localparam int unsigned OROW_W = 12;     // output row counter
	localparam int unsigned SQRT_STEPS = 8;

	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic load;      // latch accepted input word
		logic rd;        // read both line stores
		logic update;    // write line stores, shift window, step input position
		logic calc;      // gradients and sum of squares
		logic sqrt_step; // one root bit
		logic commit;    // load output register, step output position
	} sem_cmd_t;

	typedef struct packed {
		logic drop;      // early flush, no effect
		logic emit;      // this word produces a result
		logic out_free;  // output register can take a word
	} sem_status_t;

endpackage

// ===== sv/sobel_edge_magnitude.sv =====
// Sobel edge magnitude over a BGR raster stream. Each pixel becomes gray,
// passes through two line stores and a 3x3 window, and yields
// min(255, floor(sqrt(gx^2 + gy^2))) with clamped gradients and zero taps
// outside the frame. Results lag by one row plus one pixel; send W+1 flush
// words after the frame to drain it. Items are handled one at a time by a
// sequencer: a word that yields no result passes through accept, line store
// read and window update; an early flush ends after the read; a word that
// yields one goes on through the gradient step, the 8-step bit-serial square
// root and the output register, which waits for the receiver.
// A config write restarts the frame. Line stores need no clearing after reset.
module sobel_edge_magnitude import sem_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       blue,
	input  logic [7:0]       green,
	input  logic [7:0]       red,
	input  logic             flush,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       edge_res,
	output logic             last,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	sem_cmd_t    cmd;
	sem_status_t status;

	sem_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .cmd(cmd)
	);

	sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.blue(blue), .green(green), .red(red), .flush(flush),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.edge_res(edge_res), .last(last), .out_valid(out_valid), .out_ready(out_ready)
	);

endmodule

// ===== sv/sem_ctrl.sv =====
// sequencer for the sobel edge magnitude block
// depends on sem_pkg; drives sem_datapath by command struct
module sem_ctrl import sem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sem_status_t status,
	output sem_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_UPDATE, S_CALC, S_SQRT, S_OUT
	} state_t;

	localparam int unsigned SC_W = $clog2(SQRT_STEPS);

	state_t          state_q;
	logic [SC_W-1:0] step_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_ready & in_valid;
		cmd.rd = (state_q == S_READ);
		cmd.update = (state_q == S_UPDATE);
		cmd.calc = (state_q == S_CALC);
		cmd.sqrt_step = (state_q == S_SQRT);
		cmd.commit = (state_q == S_OUT) & status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= status.drop ? S_IDLE : S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= status.emit ? S_CALC : S_IDLE;
				end
				S_CALC: begin
					step_q <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == SC_W'(SQRT_STEPS - 1)) state_q <= S_OUT;
				end
				S_OUT: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.rd && !cmd.update && !cmd.calc)
		else $error("input taken while busy");
	a_read_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.rd)
		else $error("no line store read after accept");
	a_calc_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && status.emit |=> cmd.calc)
		else $error("result lost");

endmodule

// ===== sv/sem_datapath.sv =====
// line stores, window, gray conversion, sobel gradients, bit-serial root,
// position counters, config registers and output register; depends on sem_pkg
module sem_datapath import sem_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sem_cmd_t         cmd,
	output sem_status_t      status,
	input  logic [7:0]       blue,
	input  logic [7:0]       green,
	input  logic [7:0]       red,
	input  logic             flush,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output logic [7:0]       edge_res,
	output logic             last,
	output logic             out_valid,
	input  logic             out_ready
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

	logic [WCFG_W-1:0] cfg_w_q;
	logic [HCFG_W-1:0] cfg_h_q;
	logic [WW-1:0]     w_eff;
	logic [HCFG_W-1:0] h_eff;

	logic [CW-1:0]     in_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [CW-1:0]     ocol_q;
	logic [OROW_W-1:0] orow_q;

	logic [7:0] blue_q, green_q, red_q, gray_q, top_q, mid_q;
	logic       flush_q;
	logic [7:0] line_upper [MAX_WIDTH];
	logic [7:0] line_lower [MAX_WIDTH];
	logic [7:0] win_q [3][3];

	logic              in_frame;
	logic [23:0]       gray_sum;
	logic              col_wrap;
	logic              at_left, at_right, at_top, at_bottom;
	logic [7:0]        tap [3][3];
	logic signed [11:0] gx, gy;
	logic [7:0]        ax, ay;
	logic [16:0]       sumsq;

	logic [15:0] rad_q;
	logic [10:0] rem_q;
	logic [7:0]  root_q;
	logic        sat_q, last_c_q;
	logic [10:0] rem_n, trial;

	logic [7:0] edge_q;
	logic       last_q, out_valid_q;

	// out-of-range sizes act as the nearest legal one
	always_comb begin
		if (cfg_w_q == '0) w_eff = WW'(1);
		else if (32'(cfg_w_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(cfg_w_q);
		if (cfg_h_q == '0) h_eff = HCFG_W'(1);
		else if (32'(cfg_h_q) > MAX_HEIGHT) h_eff = HCFG_W'(MAX_HEIGHT);
		else h_eff = cfg_h_q;
	end

	assign in_frame = 32'(in_row_q) < 32'(h_eff);
	assign gray_sum = 24'(19595) * 24'(red_q) + 24'(38470) * 24'(green_q)
		+ 24'(7471) * 24'(blue_q);
	assign col_wrap = 32'(in_col_q) + 1 >= 32'(w_eff);

	assign status.drop = in_frame & flush_q;
	assign status.emit = !((in_row_q == '0) || (in_row_q == ROW_W'(1) && in_col_q == '0));
	assign status.out_free = !out_valid_q || out_ready;

	assign at_top = (orow_q == '0);
	assign at_bottom = 32'(orow_q) + 1 >= 32'(h_eff);
	assign at_left = (ocol_q == '0);
	assign at_right = 32'(ocol_q) + 1 >= 32'(w_eff);

	// taps outside the frame read as zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				tap[i][j] = win_q[i][j];
				if ((i == 0 && at_top) || (i == 2 && at_bottom)
					|| (j == 0 && at_left) || (j == 2 && at_right)) tap[i][j] = '0;
			end
		end
		gx = 12'(tap[0][2]) - 12'(tap[0][0]) + (12'(tap[1][2]) <<< 1)
			- (12'(tap[1][0]) <<< 1) + 12'(tap[2][2]) - 12'(tap[2][0]);
		gy = 12'(tap[0][0]) + (12'(tap[0][1]) <<< 1) + 12'(tap[0][2])
			- 12'(tap[2][0]) - (12'(tap[2][1]) <<< 1) - 12'(tap[2][2]);
		if (gx < 0) ax = '0;
		else if (gx > 12'sd255) ax = 8'hff;
		else ax = gx[7:0];
		if (gy < 0) ay = '0;
		else if (gy > 12'sd255) ay = 8'hff;
		else ay = gy[7:0];
		sumsq = 17'(16'(ax) * 16'(ax)) + 17'(16'(ay) * 16'(ay));
	end

	// restoring square root, one bit a step
	assign rem_n = {rem_q[8:0], rad_q[15:14]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			blue_q <= blue;
			green_q <= green;
			red_q <= red;
			flush_q <= flush;
		end
		if (cmd.rd) begin
			top_q <= line_upper[in_col_q];
			mid_q <= line_lower[in_col_q];
			gray_q <= in_frame ? gray_sum[23:16] : 8'd0;
		end
		if (cmd.update) begin
			line_upper[in_col_q] <= mid_q;
			line_lower[in_col_q] <= gray_q;
		end
		if (cmd.calc) begin
			sat_q <= sumsq >= 17'd65025;
			rad_q <= sumsq[15:0];
			rem_q <= '0;
			root_q <= '0;
			last_c_q <= at_bottom && at_right;
		end
		if (cmd.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (rem_n >= trial) begin
				rem_q <= rem_n - trial;
				root_q <= {root_q[6:0], 1'b1};
			end else begin
				rem_q <= rem_n;
				root_q <= {root_q[6:0], 1'b0};
			end
		end
		if (cmd.commit) begin
			edge_q <= sat_q ? 8'hff : root_q;
			last_q <= last_c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= WCFG_W'(640);
			cfg_h_q <= HCFG_W'(480);
			in_col_q <= '0;
			in_row_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
			end
		end else begin
			if (cmd.update) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= top_q;
				win_q[1][2] <= mid_q;
				win_q[2][2] <= gray_q;
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (last_c_q) begin
					in_col_q <= '0;
					in_row_q <= '0;
					ocol_q <= '0;
					orow_q <= '0;
				end else if (at_right) begin
					ocol_q <= '0;
					orow_q <= orow_q + 1'b1;
				end else begin
					ocol_q <= ocol_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH: cfg_w_q <= cfg_data[WCFG_W-1:0];
					REG_HEIGHT: cfg_h_q <= cfg_data[HCFG_W-1:0];
					default: ;
				endcase
				in_col_q <= '0;
				in_row_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end
		end
	end

	assign edge_res = edge_q;
	assign last = last_q;
	assign out_valid = out_valid_q;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_col_q) < 32'(w_eff))
		else $error("input column past row end");
	a_ocol_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ocol_q) < 32'(w_eff))
		else $error("output column past row end");
	a_orow_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		32'(orow_q) < 32'(h_eff))
		else $error("output row past frame end");

endmodule

// ===== dv/tb_sobel_edge_magnitude.sv =====
// testbench for sobel_edge_magnitude: directed table, register extremes and random frames, all
// checked against an in-bench prediction of gray conversion, line stores, window and magnitude
// depends on sem_pkg and sobel_edge_magnitude
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;
	import sem_pkg::*;

	localparam int unsigned LINE_DEPTH = 2048;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SETTLE = 30;
	localparam int unsigned RANDOM_WORDS = 300;
	localparam int unsigned PART_WORDS = 20;

	typedef struct {
		logic [7:0] edge_res;
		logic last;
	} edge_word_t;

	typedef struct {
		logic [7:0] b, g, r;
		logic f;
		bit typed;
		logic [7:0] t_edge;
		logic t_last;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, flush, out_valid, out_ready, last, cfg_we;
	logic [7:0] blue, green, red, edge_res;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	edge_word_t edge_expected[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit no_gaps = 0;
	bit hold_req = 0;

	// predictor state
	logic [7:0] gray_up [LINE_DEPTH];
	logic [7:0] gray_lo [LINE_DEPTH];
	logic [7:0] win [3][3];
	int unsigned col_in, row_in, out_pos;
	int unsigned width_reg, height_reg;

	sobel_edge_magnitude uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.blue(blue), .green(green), .red(red), .flush(flush),
		.out_valid(out_valid), .out_ready(out_ready),
		.edge_res(edge_res), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned eff_w();
		if (width_reg < 1) return 1;
		if (width_reg > LINE_DEPTH) return LINE_DEPTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_h();
		if (height_reg < 1) return 1;
		if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
		return height_reg;
	endfunction

	function automatic int unsigned clamp8(int v);
		if (v < 0) return 0;
		if (v > 255) return 255;
		return v;
	endfunction

	task automatic sobel_predict(input logic [7:0] b, g, r, input logic f,
			output bit got, output edge_word_t res);
		int unsigned w, h, total, p, c, gray, q, orow, ocol, ax, ay, sq, root;
		int gx, gy;
		int kx [3][3];
		int ky [3][3];
		kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
		ky = '{'{1, 2, 1}, '{0, 0, 0}, '{-1, -2, -1}};
		w = eff_w();
		h = eff_h();
		total = w * h;
		p = row_in * w + col_in;
		got = 0;
		gray = 0;
		if (p < total) begin
			if (f) return; // early flush is dropped
			gray = (19595 * r + 38470 * g + 7471 * b) >> 16;
		end
		c = (col_in >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_in;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = gray_up[c];
		win[1][2] = gray_lo[c];
		win[2][2] = 8'(gray);
		gray_up[c] = gray_lo[c];
		gray_lo[c] = 8'(gray);
		col_in++;
		if (col_in >= w) begin
			col_in = 0;
			row_in++;
		end
		if (p < w + 1) return;
		q = out_pos;
		orow = q / w;
		ocol = q % w;
		gx = 0;
		gy = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				// taps outside the frame count as zero
				if ((i == 0 && orow == 0) || (i == 2 && orow + 1 >= h)) continue;
				if ((j == 0 && ocol == 0) || (j == 2 && ocol + 1 >= w)) continue;
				gx += kx[i][j] * int'(win[i][j]);
				gy += ky[i][j] * int'(win[i][j]);
			end
		ax = clamp8(gx);
		ay = clamp8(gy);
		sq = ax * ax + ay * ay;
		root = 0;
		while ((root + 1) * (root + 1) <= sq) root++;
		res.edge_res = (root > 255) ? 8'd255 : root[7:0];
		res.last = (q + 1 >= total);
		got = 1;
		if (res.last) begin
			col_in = 0;
			row_in = 0;
			out_pos = 0;
		end else begin
			out_pos = q + 1;
		end
	endtask

	// one word offered until taken; a typed expectation replaces the predicted one
	task automatic push_word(input logic [7:0] b, g, r, input logic f,
			input bit typed = 0, input logic [7:0] t_edge = 0, input logic t_last = 0);
		bit got;
		edge_word_t res;
		in_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		flush <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sobel_predict(b, g, r, f, got, res);
		if (got) begin
			if (typed) begin
				res.edge_res = t_edge;
				res.last = t_last;
			end
			edge_expected.push_back(res);
		end
		if (!no_gaps && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// sender pauses until every result is back, then lets the block settle
	task automatic drain_all();
		in_valid <= 1'b0;
		@(posedge clk);
		while (edge_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) width_reg = val & 13'hFFF;
		else height_reg = val;
		col_in = 0;
		row_in = 0;
		out_pos = 0;
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		drain_all();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic random_pixel(output logic [7:0] b, g, r);
		int unsigned k;
		k = $urandom_range(9);
		if (k == 0) {b, g, r} = 24'h000000;
		else if (k == 1) {b, g, r} = 24'hFFFFFF;
		else {b, g, r} = 24'($urandom);
	endtask

	// the first rows of a tall frame, cut short by the next register write
	task automatic part_frame();
		logic [7:0] b, g, r;
		for (int unsigned k = 0; k < PART_WORDS; k++) begin
			random_pixel(b, g, r);
			push_word(b, g, r, 1'b0);
		end
	endtask

	// a frame of pixels with stray early flushes, then the drain, then a little noise
	task automatic run_frame(inout int unsigned counted);
		int unsigned w, h;
		logic [7:0] b, g, r;
		w = eff_w();
		h = eff_h();
		for (int unsigned p = 0; p < w * h; p++) begin
			if ($urandom_range(99) < 8) begin
				random_pixel(b, g, r);
				push_word(b, g, r, 1'b1);
			end
			random_pixel(b, g, r);
			push_word(b, g, r, 1'b0);
			counted++;
		end
		for (int unsigned k = 0; k <= w; k++) begin
			random_pixel(b, g, r);
			push_word(b, g, r, $urandom_range(99) < 70);
			counted++;
		end
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) begin
				random_pixel(b, g, r);
				push_word(b, g, r, 1'($urandom_range(1)));
			end
	endtask

	// receiver
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				out_ready <= no_gaps || ($urandom_range(99) >= 36);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (edge_expected.size() == 0) begin
				$error("unexpected word: edge_res %0d last %0d", edge_res, last);
				errors++;
			end else begin
				edge_word_t e;
				e = edge_expected.pop_front();
				if (edge_res !== e.edge_res) begin
					$error("edge_res: expected %0d, got %0d", e.edge_res, edge_res);
					errors++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					errors++;
				end
			end
		end
	end

	initial begin
		dir_row_t dir_tab [15];
		int unsigned counted;
		int unsigned phase;
		// 3x3 frame, black left column and white elsewhere
		dir_tab = '{
			'{8'hAA, 8'h55, 8'hFF, 1'b1, 0, 8'd0, 1'b0},
			'{8'h00, 8'h00, 8'h00, 1'b0, 0, 8'd0, 1'b0},
			'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 8'd0, 1'b0},
			'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 8'd0, 1'b0},
			'{8'h00, 8'h00, 8'h00, 1'b0, 0, 8'd0, 1'b0},
			'{8'h3C, 8'hC3, 8'h81, 1'b1, 0, 8'd0, 1'b0},
			'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 8'd0, 1'b0},
			'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 8'd0, 1'b0},
			'{8'h00, 8'h00, 8'h00, 1'b0, 0, 8'd0, 1'b0},
			'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 8'd0, 1'b0},
			'{8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 8'd0, 1'b0},
			'{8'h00, 8'h00, 8'h00, 1'b1, 0, 8'd0, 1'b0},
			'{8'h12, 8'h34, 8'h56, 1'b0, 0, 8'd0, 1'b0},
			'{8'hFF, 8'hFF, 8'hFF, 1'b1, 0, 8'd0, 1'b0},
			'{8'h00, 8'h00, 8'h00, 1'b1, 1, 8'd255, 1'b1}
		};
		arst_n = 1'b0;
		in_valid = 1'b0;
		blue = 8'd0;
		green = 8'd0;
		red = 8'd0;
		flush = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		width_reg = 640;
		height_reg = 480;
		col_in = 0;
		row_in = 0;
		out_pos = 0;
		foreach (gray_up[i]) begin
			gray_up[i] = 8'd0;
			gray_lo[i] = 8'd0;
		end
		foreach (win[i, j]) win[i][j] = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_frame(13'd3, 13'd3);
		foreach (dir_tab[i])
			push_word(dir_tab[i].b, dir_tab[i].g, dir_tab[i].r, dir_tab[i].f,
				dir_tab[i].typed, dir_tab[i].t_edge, dir_tab[i].t_last);

		counted = 0;
		// zero and small sizes for both registers, large and out-of-range heights
		set_frame(13'd0, 13'd0);
		run_frame(counted);
		set_frame(13'd1, 13'd1);
		no_gaps = 1;
		run_frame(counted);
		no_gaps = 0;
		set_frame(13'd1, 13'h1FFF);
		part_frame();
		set_frame(13'd2, 13'd4096);
		part_frame();

		counted = 0;
		phase = 0;
		while (counted < RANDOM_WORDS) begin
			set_frame(CFG_W'($urandom_range(1, 9)), CFG_W'($urandom_range(1, 6)));
			if (phase == 1) hold_req = 1;
			no_gaps = (phase == 3);
			repeat ($urandom_range(1, 2)) run_frame(counted);
			phase++;
		end
		no_gaps = 0;

		drain_all();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sobel_edge_magnitude.f =====
sv/sem_pkg.sv
sv/sem_ctrl.sv
sv/sem_datapath.sv
sv/sobel_edge_magnitude.sv
dv/tb_sobel_edge_magnitude.sv
